// ----- hdl/resp_reply_stream_parser_core_macros.svh -----
// Assertion macros used by the reply parser top level.
`ifndef RESP_REPLY_STREAM_PARSER_CORE_MACROS_SVH
`define RESP_REPLY_STREAM_PARSER_CORE_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define RRSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define RRSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hdl/rrsp_pkg.sv -----
// Types, codes and constants of the reply stream parser.
`default_nettype none
package rrsp_pkg;

  localparam int CountWidth = 16;
  localparam int FifoDepth  = 4;
  localparam int PtrWidth   = $clog2(FifoDepth);
  localparam int CntWidth   = $clog2(FifoDepth + 1);

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [2:0] KindSimple = 3'd0;
  localparam logic [2:0] KindError  = 3'd1;
  localparam logic [2:0] KindInt    = 3'd2;
  localparam logic [2:0] KindBulk   = 3'd3;
  localparam logic [2:0] KindNil    = 3'd4;

  localparam logic [1:0] ErrNone  = 2'd0;
  localparam logic [1:0] ErrEmpty = 2'd1;
  localparam logic [1:0] ErrType  = 2'd2;
  localparam logic [1:0] ErrCount = 2'd3;

  // nil header match progress
  localparam logic [1:0] NilIdle  = 2'd0;
  localparam logic [1:0] NilMinus = 2'd1;
  localparam logic [1:0] NilOne   = 2'd2;
  localparam logic [1:0] NilNone  = 2'd3;

  typedef enum logic [7:0] {
    MTYPE    = 8'b0000_0001,
    MSIMPLE  = 8'b0000_0010,
    MERROR   = 8'b0000_0100,
    MINT     = 8'b0000_1000,
    MBHDR    = 8'b0001_0000,
    MCOUNT   = 8'b0010_0000,
    MBULK    = 8'b0100_0000,
    MDISCARD = 8'b1000_0000
  } mode_e;

  typedef struct packed {
    mode_e                 mode;
    logic [1:0]            len;
    logic                  crp;
    logic                  bulk_next;
    logic [1:0]            nil;
    logic [CountWidth-1:0] left;
    logic [CountWidth-1:0] accum;
  } st_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       elem_end;
    logic [2:0] elem_kind;
    logic       reply_done;
    logic [1:0] err_code;
  } res_t;

  typedef struct packed {
    res_t res;
    logic last;
  } out_t;

  // results produced by one accepted byte
  typedef struct packed {
    logic [1:0]      num;
    out_t [1:0]      item;
  } push_t;

endpackage
`default_nettype wire

// ----- hdl/rrsp_parser.sv -----
// Line parser: state registers and the per-byte next-state and result logic.
`default_nettype none
module rrsp_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     byte_i,
  output rrsp_pkg::push_t push_o
);
  import rrsp_pkg::*;

  typedef struct packed {
    st_t  st;
    logic emit;
    res_t res;
  } step_t;

  st_t   state_q, state_d;
  push_t push;

  function automatic st_t reset_state();
    st_t s;
    s.mode      = MTYPE;
    s.len       = '0;
    s.crp       = 1'b0;
    s.bulk_next = 1'b0;
    s.nil       = NilIdle;
    s.left      = CountWidth'(1);
    s.accum     = '0;
    return s;
  endfunction

  function automatic step_t fail(logic [1:0] err, logic mid_line);
    step_t o;
    o.st  = reset_state();
    o.emit = 1'b1;
    o.res = '0;
    o.res.err_code = err;
    if (mid_line) o.st.mode = MDISCARD;
    return o;
  endfunction

  function automatic logic [1:0] bump(logic [1:0] len);
    return (len == 2'd3) ? len : len + 2'd1;
  endfunction

  function automatic step_t finish(st_t s, logic [2:0] kind);
    step_t o;
    logic [CountWidth-1:0] left;
    left = (s.left != '0) ? s.left - CountWidth'(1) : s.left;
    o.st = s;
    o.st.left = left;
    o.emit = 1'b1;
    o.res = '0;
    o.res.elem_end  = 1'b1;
    o.res.elem_kind = kind;
    if (left == '0) begin
      o.res.reply_done = 1'b1;
      o.st = reset_state();
    end else begin
      o.st.mode = MTYPE;
    end
    return o;
  endfunction

  function automatic step_t content_byte(st_t s, logic [7:0] b);
    step_t o;
    logic [CountWidth+3:0] v;
    // accum * 10 + digit
    v = ({4'b0, s.accum} << 3) + ({4'b0, s.accum} << 1)
        + (CountWidth+4)'(b - ChZero);
    o.st = s;
    o.emit = 1'b0;
    o.res = '0;
    unique case (s.mode)
      MTYPE: begin
        o.st.len   = '0;
        o.st.nil   = NilIdle;
        o.st.accum = '0;
        case (b)
          ChPlus:   o.st.mode = MSIMPLE;
          ChMinus:  o.st.mode = MERROR;
          ChColon:  o.st.mode = MINT;
          ChDollar: o.st.mode = MBHDR;
          ChStar:   o.st.mode = MCOUNT;
          default:  o = fail(ErrType, 1'b1);
        endcase
      end
      MSIMPLE, MERROR, MINT, MBULK: begin
        o.emit = 1'b1;
        o.res.data_byte  = b;
        o.res.byte_valid = 1'b1;
        o.st.len = bump(s.len);
      end
      MBHDR: begin
        if (s.nil == NilIdle)       o.st.nil = (b == ChMinus) ? NilMinus : NilNone;
        else if (s.nil == NilMinus) o.st.nil = (b == ChOne) ? NilOne : NilNone;
        else                        o.st.nil = NilNone;
        o.st.len = bump(s.len);
      end
      MCOUNT: begin
        if (b >= ChZero && b <= ChNine) begin
          if (v[CountWidth+3:CountWidth] != '0) begin
            o = fail(ErrCount, 1'b1);
          end else begin
            o.st.accum = v[CountWidth-1:0];
            o.st.len   = bump(s.len);
          end
        end else begin
          o = fail(ErrCount, 1'b1);
        end
      end
      MDISCARD: ;
      default: ;
    endcase
    return o;
  endfunction

  function automatic step_t line_end(st_t s);
    step_t o;
    logic [CountWidth:0] total;
    total = (s.left != '0)
      ? {1'b0, s.left} + {1'b0, s.accum} - (CountWidth+1)'(1)
      : {1'b0, s.accum};
    o.st = s;
    o.emit = 1'b0;
    o.res = '0;
    unique case (s.mode)
      MTYPE:   o = fail(ErrEmpty, 1'b0);
      MSIMPLE: o = finish(s, KindSimple);
      MERROR:  o = finish(s, KindError);
      MINT:    o = finish(s, KindInt);
      MBHDR: begin
        if (s.nil == NilOne) begin
          o = finish(s, KindNil);
        end else begin
          o.st.bulk_next = 1'b1;
          o.st.mode = MBULK;
          o.st.len  = '0;
        end
      end
      MCOUNT: begin
        if (s.len == '0 || total[CountWidth]) begin
          o = fail(ErrCount, 1'b0);
        end else if (total == '0) begin
          // "*0": reply complete without an element
          o.emit = 1'b1;
          o.res.reply_done = 1'b1;
          o.st = reset_state();
        end else begin
          o.st.left = total[CountWidth-1:0];
          o.st.mode = MTYPE;
        end
      end
      MBULK: begin
        o.st.bulk_next = 1'b0;
        o = finish(o.st, KindBulk);
      end
      MDISCARD: o.st.mode = MTYPE;
      default:  o.st.mode = MTYPE;
    endcase
    return o;
  endfunction

  always_comb begin
    st_t   s;
    step_t o;
    logic  lf;
    logic  slot;
    s = state_q;
    lf = 1'b0;
    slot = 1'b0;
    push = '0;
    o = '0;
    // a held CR resolves first: line end, or a plain content byte
    if (s.crp) begin
      s.crp = 1'b0;
      if (byte_i == ChLf) begin
        lf = 1'b1;
        o = line_end(s);
      end else begin
        o = content_byte(s, ChCr);
      end
      s = o.st;
      if (o.emit) begin
        push.item[0].res = o.res;
        push.num = 2'd1;
        slot = 1'b1;
      end
    end
    if (!lf) begin
      if (byte_i == ChCr) begin
        s.crp = 1'b1;
      end else begin
        o = content_byte(s, byte_i);
        s = o.st;
        if (o.emit) begin
          push.item[slot].res = o.res;
          push.num = push.num + 2'd1;
        end
      end
    end
    if (push.num == 2'd1) push.item[0].last = 1'b1;
    if (push.num == 2'd2) push.item[1].last = 1'b1;
    if (!accept_i) push.num = '0;
    state_d = accept_i ? s : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= reset_state();
    end else begin
      state_q <= state_d;
    end
  end

  assign push_o = push;

endmodule
`default_nettype wire

// ----- hdl/rrsp_out_fifo.sv -----
// Result queue: takes up to two words per cycle, hands out one per cycle while ready_i is high.
`default_nettype none
module rrsp_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rrsp_pkg::push_t push_i,
  output logic            space_o,
  output rrsp_pkg::out_t  item_o,
  output logic            valid_o,
  input  logic            ready_i
);
  import rrsp_pkg::*;

  out_t [FifoDepth-1:0] mem_q;
  logic [PtrWidth-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  // room for the worst case of two words from one byte
  assign space_o = (cnt_q <= CntWidth'(FifoDepth - 2));

  always_comb begin
    wr_d  = wr_q + PtrWidth'(push_i.num);
    rd_d  = rd_q + PtrWidth'(pop);
    cnt_d = cnt_q + CntWidth'(push_i.num) - CntWidth'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q] <= push_i.item[0];
    if (push_i.num == 2'd2) mem_q[wr_q + PtrWidth'(1)] <= push_i.item[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/resp_reply_stream_parser_core.sv -----
// Top level of the reply stream parser: byte stream in, element results out.
//
//  channel  dir  fields (tdata / tuser / tlast)
//  s_axis   in   tdata[7:0] in_byte
//  m_axis   out  tdata[7:0] data_byte, [8] elem_end, [9] reply_done,
//                [11:10] err_code, [15:12] zero; tuser[0] byte_valid,
//                [3:1] elem_kind; tlast last
//
// One byte is accepted per cycle while s_axis_tready is high; its zero, one or two result words go
// into a four-word queue in the same cycle and can show on m_axis from the next.
// A byte that follows a held CR can give two words, so one word per byte
// is the sustained rate set by the single-word output port.
// s_axis_tready drops while the queue holds more than two words.
// Reset is asynchronous and clears parser state and queue; no sweep.
`default_nettype none
`include "resp_reply_stream_parser_core_macros.svh"
module resp_reply_stream_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [8] elem_end, [9] reply_done,
                                      // [11:10] err_code, [15:12] zero
  output logic [3:0]  m_axis_tuser,   // [0] byte_valid, [3:1] elem_kind
  output logic        m_axis_tlast
);
  import rrsp_pkg::*;

  logic  accept;
  push_t push;
  out_t  item;
  logic  space;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = space;

  rrsp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .push_o   (push)
  );

  rrsp_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .item_o  (item),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {4'b0, item.res.err_code, item.res.reply_done,
                         item.res.elem_end, item.res.data_byte};
  assign m_axis_tuser = {item.res.elem_kind, item.res.byte_valid};
  assign m_axis_tlast = item.last;

  // a finished reply or an error ends the byte's results
  `RRSP_ASSERT(a_done_is_last, (m_axis_tvalid && item.res.reply_done) |-> item.last, "reply done word not marked last")
  `RRSP_ASSERT(a_error_is_last, (m_axis_tvalid && item.res.err_code != ErrNone) |-> item.last, "error word not marked last")
  `RRSP_ASSERT(a_stall_has_words, !s_axis_tready |-> m_axis_tvalid, "input stalled with empty queue")

endmodule
`default_nettype wire
